// ===== hw/rtl/ptd_pkg.sv =====
// Shared widths, register indexes and the per-word sideband record for the
// point-to-disk distance pipeline. No dependencies.
package ptd_pkg;
	localparam int DW = 33;   // point minus center, signed
	localparam int TW = 36;   // projection length along the normal, signed
	localparam int VW = 36;   // in-plane offset, signed
	localparam int MW = 35;   // in-plane offset magnitude
	localparam int RW = 31;   // radius
	localparam int LW = 70;   // squared in-plane length
	localparam int SB = 35;   // square root result bits
	localparam int QB = 33;   // scale factor bits, Q1.32 up to 1.0
	localparam int EW = 37;   // offset from closest point, signed
	localparam int OW = 63;   // result width

	localparam logic [OW-1:0] DIST_MAX = '1;

	typedef enum logic [2:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_CENTER_Z    = 3'd2,
		REG_NORMAL_X    = 3'd3,
		REG_NORMAL_Y    = 3'd4,
		REG_NORMAL_Z    = 3'd5,
		REG_DISK_RADIUS = 3'd6
	} reg_idx_t;

	// data that rides along with a word through the long stages
	typedef struct packed {
		logic [2:0][DW-1:0] d;
		logic [2:0][MW-1:0] vm;
		logic [2:0]         vneg;
		logic [RW-1:0]      r;
		logic               clamp;
	} item_t;
endpackage

// ===== hw/rtl/point_to_disk_distance_squared.sv =====
// Squared distance from a query point to a disk, fully pipelined.
// Depends on ptd_pkg, ptd_mul, ptd_delay, ptd_sqrt and ptd_div.
//
// Usage:
//   Input words (point_x/y/z, signed Q16.16) enter on in_valid when in_stall
//   is low; result words (dist_sq, unsigned Q31.32, and saturated) leave on
//   out_valid when out_stall is low. One result per input, in order.
//   Disk registers are written through cfg_we/cfg_index/cfg_data while the
//   pipeline is empty; unknown indexes are dropped.
// Depth: 82 register stages, from the stage that accepts the input word to
//   the out_valid stage.
// Throughput: one word per cycle unless stalled. The square root (35 stages,
//   one result bit each) and the clamp divider (33 stages, one quotient bit
//   each) set most of the latency; every stage is occupied by its own word.
// Stall: when out_stall holds a valid result the whole pipeline freezes and
//   in_stall is raised in the same cycle; nothing is lost or duplicated.
// Reset: arst_n clears all valid bits and loads the default disk (center at
//   the origin, normal +z, radius 1.0).
module point_to_disk_distance_squared import ptd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [OW-1:0]     dist_sq,
	output logic              saturated
);
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// disk registers
	logic signed [31:0] center_q [3];
	logic signed [15:0] normal_q [3];
	logic [RW-1:0]      radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			normal_q[0] <= '0;
			normal_q[1] <= '0;
			normal_q[2] <= 16'sd32767;
			radius_q    <= RW'(65536);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CENTER_X:    center_q[0] <= cfg_data;
				REG_CENTER_Y:    center_q[1] <= cfg_data;
				REG_CENTER_Z:    center_q[2] <= cfg_data;
				REG_NORMAL_X:    normal_q[0] <= cfg_data[15:0];
				REG_NORMAL_Y:    normal_q[1] <= cfg_data[15:0];
				REG_NORMAL_Z:    normal_q[2] <= cfg_data[15:0];
				REG_DISK_RADIUS: radius_q    <= cfg_data[RW-1:0];
				default: ;
			endcase
		end
	end

	logic signed [31:0] pt [3];
	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	// valid bits of the short stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s8, v_se;
	logic v_mul, v_sq, v_dv, v_sc, v_em;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s8 <= 1'b0; v_se <= 1'b0; out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s8 <= v_mul; v_se <= v_sc; out_valid <= v_em;
		end
	end

	// stage 1..5: offset, projection onto the plane
	logic signed [DW-1:0] d_s1 [3], d_s2 [3], d_s3 [3], d_s4 [3], d_s5 [3];
	logic signed [48:0]   nd_s2 [3];
	logic signed [TW-1:0] t_s3;
	logic signed [51:0]   nt_s4 [3];
	logic [MW-1:0]        vm_s5 [3];
	logic [2:0]           vneg_s5;
	logic signed [51:0]   dot;

	assign dot = 52'(nd_s2[0]) + 52'(nd_s2[1]) + 52'(nd_s2[2]) + 52'sd16384;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= DW'(pt[i]) - DW'(center_q[i]);
				nd_s2[i] <= normal_q[i] * d_s1[i];
				d_s2[i]  <= d_s1[i];
				d_s3[i]  <= d_s2[i];
				nt_s4[i] <= normal_q[i] * t_s3;
				d_s4[i]  <= d_s3[i];
				d_s5[i]  <= d_s4[i];
			end
			t_s3 <= TW'(dot >>> 15);
		end
	end

	// in-plane offset with half-up rounding of n*t/2^15
	for (genvar i = 0; i < 3; i++) begin : g_plane
		logic signed [51:0]   rn;
		logic signed [VW-1:0] v;
		assign rn = (nt_s4[i] + 52'sd16384) >>> 15;
		assign v  = VW'(d_s4[i]) - VW'(rn);
		always_ff @(posedge clk) begin
			if (en) begin
				vneg_s5[i] <= v[VW-1];
				vm_s5[i]   <= MW'(v[VW-1] ? -v : v);
			end
		end
	end

	// squared in-plane length and squared radius
	logic [2*MW-1:0] vsq [3];
	logic [2*RW-1:0] rr;
	item_t           it_s5, it_mul, it_cl, it_s8, it_sq, it_dv, it_sc;
	logic [LW-1:0]   len2_s8;
	logic [LW+1:0]   len2;

	for (genvar i = 0; i < 3; i++) begin : g_vsq
		ptd_mul #(.AW(MW), .BW(MW)) u_mul (
			.clk(clk), .en(en), .a(vm_s5[i]), .b(vm_s5[i]), .p(vsq[i])
		);
	end
	ptd_mul #(.AW(RW), .BW(RW)) u_rr (
		.clk(clk), .en(en), .a(radius_q), .b(radius_q), .p(rr)
	);

	always_comb begin
		it_s5 = '0;
		for (int i = 0; i < 3; i++) begin
			it_s5.d[i]  = d_s5[i];
			it_s5.vm[i] = vm_s5[i];
		end
		it_s5.vneg = vneg_s5;
		it_s5.r    = radius_q;
	end

	ptd_delay #(.W($bits(item_t)), .N(2)) u_dl_mul (
		.clk(clk), .arst_n(arst_n), .en(en), .din(it_s5), .dout(it_mul)
	);
	ptd_delay #(.W(1), .N(2)) u_vl_mul (
		.clk(clk), .arst_n(arst_n), .en(en), .din(v_s5), .dout(v_mul)
	);

	assign len2 = (LW+2)'(vsq[0]) + (LW+2)'(vsq[1]) + (LW+2)'(vsq[2]);

	// clamp decision
	always_comb begin
		it_cl       = it_mul;
		it_cl.clamp = len2 > (LW+2)'(rr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len2_s8 <= LW'(len2);
			it_s8   <= it_cl;
		end
	end

	// square root, then scale = r * 2^32 / len
	logic [SB-1:0] len;
	logic [QB-1:0] scale;

	ptd_sqrt u_sqrt (.clk(clk), .en(en), .x(len2_s8), .root(len));
	ptd_delay #(.W($bits(item_t)), .N(SB)) u_dl_sq (
		.clk(clk), .arst_n(arst_n), .en(en), .din(it_s8), .dout(it_sq)
	);
	ptd_delay #(.W(1), .N(SB)) u_vl_sq (
		.clk(clk), .arst_n(arst_n), .en(en), .din(v_s8), .dout(v_sq)
	);

	ptd_div u_div (.clk(clk), .en(en), .r(it_sq.r), .len(len), .quo(scale));
	ptd_delay #(.W($bits(item_t)), .N(QB)) u_dl_dv (
		.clk(clk), .arst_n(arst_n), .en(en), .din(it_sq), .dout(it_dv)
	);
	ptd_delay #(.W(1), .N(QB)) u_vl_dv (
		.clk(clk), .arst_n(arst_n), .en(en), .din(v_sq), .dout(v_dv)
	);

	// shortened offset
	logic [MW+QB-1:0] vs [3];
	for (genvar i = 0; i < 3; i++) begin : g_scale
		ptd_mul #(.AW(MW), .BW(QB)) u_mul (
			.clk(clk), .en(en), .a(it_dv.vm[i]), .b(scale), .p(vs[i])
		);
	end
	ptd_delay #(.W($bits(item_t)), .N(2)) u_dl_sc (
		.clk(clk), .arst_n(arst_n), .en(en), .din(it_dv), .dout(it_sc)
	);
	ptd_delay #(.W(1), .N(2)) u_vl_sc (
		.clk(clk), .arst_n(arst_n), .en(en), .din(v_dv), .dout(v_sc)
	);

	// offset from closest point to the query point
	logic [EW-1:0] em_se [3];
	for (genvar i = 0; i < 3; i++) begin : g_err
		logic [MW+QB:0]       rq;
		logic [VW-1:0]        mg;
		logic signed [VW-1:0] vv;
		logic signed [EW-1:0] e;
		assign rq = (MW+QB+1)'(vs[i]) + ((MW+QB+1)'(1) << 31);
		assign mg = it_sc.clamp ? VW'(rq >> 32) : VW'(it_sc.vm[i]);
		assign vv = it_sc.vneg[i] ? -$signed(mg) : $signed(mg);
		assign e  = EW'($signed(it_sc.d[i])) - EW'(vv);
		always_ff @(posedge clk) begin
			if (en) begin
				em_se[i] <= e[EW-1] ? EW'(-e) : EW'(e);
			end
		end
	end

	// squared distance and saturation
	logic [2*EW-1:0] esq [3];
	logic [2*EW+1:0] dsum;
	for (genvar i = 0; i < 3; i++) begin : g_esq
		ptd_mul #(.AW(EW), .BW(EW)) u_mul (
			.clk(clk), .en(en), .a(em_se[i]), .b(em_se[i]), .p(esq[i])
		);
	end
	ptd_delay #(.W(1), .N(2)) u_vl_em (
		.clk(clk), .arst_n(arst_n), .en(en), .din(v_se), .dout(v_em)
	);

	assign dsum = (2*EW+2)'(esq[0]) + (2*EW+2)'(esq[1]) + (2*EW+2)'(esq[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			saturated <= |dsum[2*EW+1:OW];
			dist_sq   <= (|dsum[2*EW+1:OW]) ? DIST_MAX : dsum[OW-1:0];
		end
	end

	// checks
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> dist_sq == DIST_MAX)
		else $error("saturated word without maximum distance");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output stage empty");
endmodule

// ===== hw/rtl/ptd_mul.sv =====
// Two-stage unsigned multiplier built from four half-width partial products.
// Standalone; used by point_to_disk_distance_squared.
module ptd_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic [AW+BW-1:0] p
);
	localparam int AL = (AW + 1) / 2;
	localparam int AH = AW - AL;
	localparam int BL = (BW + 1) / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic [AL+BL-1:0] ll_s1;
	logic [AL+BH-1:0] lh_s1;
	logic [AH+BL-1:0] hl_s1;
	logic [AH+BH-1:0] hh_s1;

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[AL-1:0] * b[BL-1:0];
			lh_s1 <= a[AL-1:0] * b[BW-1:BL];
			hl_s1 <= a[AW-1:AL] * b[BL-1:0];
			hh_s1 <= a[AW-1:AL] * b[BW-1:BL];
		end
	end

	// recombine
	always_ff @(posedge clk) begin
		if (en) begin
			p <= PW'(ll_s1) + (PW'(lh_s1) << BL) + (PW'(hl_s1) << AL)
				+ (PW'(hh_s1) << (AL + BL));
		end
	end
endmodule

// ===== hw/rtl/ptd_delay.sv =====
// Enabled shift line that carries a word's sideband beside a long unit.
// Standalone; used by point_to_disk_distance_squared.
module ptd_delay #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [N-1:0][W-1:0] line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else if (en) begin
			line_q[0] <= din;
			for (int i = 1; i < N; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign dout = line_q[N-1];
endmodule

// ===== hw/rtl/ptd_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on ptd_pkg for widths.
module ptd_sqrt import ptd_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [LW-1:0] x,
	output logic [SB-1:0] root
);
	logic [LW-1:0]   x_s   [1:SB];
	logic [SB-1:0]   res_s [1:SB];
	logic [2*SB-1:0] sq_s  [1:SB];

	for (genvar k = 0; k < SB; k++) begin : g_stage
		localparam int B = SB - 1 - k;
		logic [LW-1:0]   x_in;
		logic [SB-1:0]   res_in;
		logic [2*SB-1:0] sq_in;
		logic [2*SB+1:0] trial;
		logic            take;

		if (k == 0) begin : g_first
			assign x_in   = x;
			assign res_in = '0;
			assign sq_in  = '0;
		end else begin : g_next
			assign x_in   = x_s[k];
			assign res_in = res_s[k];
			assign sq_in  = sq_s[k];
		end

		// (res + 2^B)^2 = res^2 + res*2^(B+1) + 2^(2B)
		assign trial = (2*SB+2)'(sq_in) + ((2*SB+2)'(res_in) << (B + 1))
			+ ((2*SB+2)'(1) << (2 * B));
		assign take = trial <= (2*SB+2)'(x_in);

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]   <= x_in;
				res_s[k+1] <= take ? (res_in | (SB'(1) << B)) : res_in;
				sq_s[k+1]  <= take ? trial[2*SB-1:0] : sq_in;
			end
		end
	end

	assign root = res_s[SB];
endmodule

// ===== hw/rtl/ptd_div.sv =====
// Pipelined restoring divider for the clamp scale floor(r * 2^32 / len),
// one quotient bit per stage. Depends on ptd_pkg for widths.
module ptd_div import ptd_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] r,
	input  logic [SB-1:0] len,
	output logic [QB-1:0] quo
);
	logic [SB:0]   rem_s [1:QB];
	logic [SB-1:0] len_s [1:QB];
	logic [QB-1:0] quo_s [1:QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [SB:0]   rem_in;
		logic [SB-1:0] len_in;
		logic [QB-1:0] quo_in;
		logic          bit_in;
		logic [SB+1:0] trial;
		logic          ge;

		// numerator is r followed by 32 zero bits; the top bits seed the remainder
		if (k == 0) begin : g_first
			assign rem_in = (SB+1)'(r[RW-1:1]);
			assign len_in = len;
			assign quo_in = '0;
			assign bit_in = r[0];
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign len_in = len_s[k];
			assign quo_in = quo_s[k];
			assign bit_in = 1'b0;
		end

		assign trial = {rem_in, bit_in};
		assign ge    = trial >= (SB+2)'(len_in);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? (SB+1)'(trial - (SB+2)'(len_in)) : trial[SB:0];
				len_s[k+1] <= len_in;
				quo_s[k+1] <= {quo_in[QB-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QB];
endmodule
